FILE: sv/ba_pkg.sv
package ba_pkg;

    // default geometry
    localparam int DEF_SPACE_WORDS = 1024;
    localparam int DEF_MIN_BLOCK   = 8;
    localparam int DEF_LEVELS      = 7;

    // request codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam int STATUS_W = 2;
    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD_FREE = 2'd2
    } status_t;

endpackage

FILE: sv/ba_flist.sv
module ba_flist #(
    parameter int DEPTH = 127,
    parameter int AW    = 7,
    parameter int DW    = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);
    // free-list stacks of all levels, one write and one registered read port
    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: sv/buddy_allocator.sv
// Buddy allocator over a SPACE_WORDS-word space. Blocks of SPACE_WORDS/2 down to MIN_BLOCK
// words sit in one stack per level in a single-port-write, registered-read list memory; the
// sizes of allocated blocks live in a granule table with a valid bit per granule. One
// request is handled at a time and s_ready is low while it runs. After reset a seeding pass
// writes the heads of the top three level stacks before the first request is taken. An
// allocate pops the nearest non-empty level, pushes the upper half of each split onto its
// level's stack and writes the granule table. A free reads the table, compares list entries
// one per cycle for buddies (at most the level's count per level walked), pulls each merged
// buddy out of its stack, shifting later entries down one per cycle, and pushes the merged
// block. The result sits in an output register; a new request is taken while it waits.
module buddy_allocator #(
    parameter int SPACE_WORDS = ba_pkg::DEF_SPACE_WORDS,
    parameter int MIN_BLOCK   = ba_pkg::DEF_MIN_BLOCK,
    parameter int LEVELS      = ba_pkg::DEF_LEVELS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [$clog2(SPACE_WORDS)-1:0]     s_request_size,
    input  logic [$clog2(SPACE_WORDS)-1:0]     s_free_addr,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ba_pkg::STATUS_W-1:0]        m_status,
    output logic [$clog2(SPACE_WORDS)-1:0]     m_block_addr
);
    import ba_pkg::*;

    localparam int ADDR_W = $clog2(SPACE_WORDS);
    localparam int LVL_W  = $clog2(LEVELS);
    localparam int SLOTS  = (2 ** LEVELS) - 1;
    localparam int SLOT_W = LEVELS;
    localparam int CNT_W  = LEVELS;
    localparam int GRAN   = SPACE_WORDS / MIN_BLOCK;
    localparam int GRAN_W = $clog2(GRAN);
    localparam int MINB_W = $clog2(MIN_BLOCK);
    localparam int TOP    = SPACE_WORDS / 2;
    localparam int NINIT  = (LEVELS < 3) ? LEVELS : 3;

    localparam logic [ADDR_W-1:0] TOP_A    = ADDR_W'(TOP);
    localparam logic [ADDR_W:0]   TOP_X    = (ADDR_W+1)'(TOP);
    localparam logic [ADDR_W:0]   SPACE_X  = (ADDR_W+1)'(SPACE_WORDS);
    localparam logic [ADDR_W-1:0] MIN_MASK = ADDR_W'(MIN_BLOCK - 1);

    typedef enum logic [12:0] {
        S_INIT   = 13'b0000000000001,
        S_IDLE   = 13'b0000000000010,
        S_A_POP  = 13'b0000000000100,
        S_A_SPLT = 13'b0000000001000,
        S_A_TBL  = 13'b0000000010000,
        S_F_TBL  = 13'b0000000100000,
        S_F_LVL  = 13'b0000001000000,
        S_F_CMP  = 13'b0000010000000,
        S_F_ROOM = 13'b0000100000000,
        S_F_RMV  = 13'b0001000000000,
        S_F_SHW  = 13'b0010000000000,
        S_F_PUSH = 13'b0100000000000,
        S_DONE   = 13'b1000000000000
    } state_t;

    function automatic logic [ADDR_W-1:0] lvl_size(input logic [LVL_W-1:0] lv);
        lvl_size = TOP_A >> lv;
    endfunction

    function automatic logic [SLOT_W-1:0] lvl_base(input logic [LVL_W-1:0] lv);
        lvl_base = (SLOT_W'(1) << lv) - SLOT_W'(1);
    endfunction

    function automatic logic [CNT_W-1:0] lvl_cap(input logic [LVL_W-1:0] lv);
        lvl_cap = CNT_W'(1) << lv;
    endfunction

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg [LEVELS];
    logic [CNT_W-1:0]      cnt_next [LEVELS];
    logic [CNT_W-1:0]      pos_reg [LEVELS];
    logic [CNT_W-1:0]      pos_next [LEVELS];
    logic [GRAN-1:0]       tvld_reg, tvld_next;
    logic [LVL_W-1:0]      lv_reg, lv_next;
    logic [LVL_W-1:0]      tgt_reg, tgt_next;
    logic [LVL_W-1:0]      start_reg, start_next;
    logic [LVL_W-1:0]      rm_lv_reg, rm_lv_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     a_reg, a_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    logic [1:0]            init_reg, init_next;
    status_t               res_st_reg, res_st_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic                  m_valid_reg, m_valid_next;
    status_t               m_status_reg, m_status_next;
    logic [ADDR_W-1:0]     m_addr_reg, m_addr_next;

    // list memory port
    logic                  fl_we, fl_re;
    logic [SLOT_W-1:0]     fl_waddr, fl_raddr;
    logic [ADDR_W-1:0]     fl_wdata, fl_rdata;

    // granule table: level of the allocated block starting there
    logic [LVL_W-1:0]      tbl_mem [GRAN];
    logic                  tbl_we, tbl_re;
    logic [GRAN_W-1:0]     tbl_waddr, tbl_raddr;
    logic [LVL_W-1:0]      tbl_wdata, tbl_rdata;

    // request decode
    logic [ADDR_W:0]       need;
    logic                  too_big;
    logic [LVL_W-1:0]      target;
    logic [LVL_W-1:0]      src;
    logic                  src_found;
    logic                  free_bad;
    logic [GRAN_W-1:0]     a_gran;

    ba_flist #(
        .DEPTH (SLOTS),
        .AW    (SLOT_W),
        .DW    (ADDR_W)
    ) u_flist (
        .aclk  (aclk),
        .we    (fl_we),
        .waddr (fl_waddr),
        .wdata (fl_wdata),
        .re    (fl_re),
        .raddr (fl_raddr),
        .rdata (fl_rdata)
    );

    always_ff @(posedge aclk) begin
        if (tbl_we) begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re) begin
            tbl_rdata <= tbl_mem[tbl_raddr];
        end
    end

    // size class and nearest non-empty level for an allocate
    always_comb begin
        need      = {1'b0, s_request_size} + (ADDR_W+1)'(1);
        too_big   = need > TOP_X;
        target    = '0;
        src       = '0;
        src_found = 1'b0;
        for (int t = 1; t < LEVELS; t++) begin
            if (need <= {1'b0, lvl_size(LVL_W'(t))}) begin
                target = LVL_W'(t);
            end
        end
        for (int l = 0; l < LEVELS; l++) begin
            if (LVL_W'(l) <= target && cnt_reg[l] != '0) begin
                src       = LVL_W'(l);
                src_found = 1'b1;
            end
        end
        free_bad = ((s_free_addr & MIN_MASK) != '0) || ({1'b0, s_free_addr} >= SPACE_X);
    end

    assign a_gran = GRAN_W'(a_reg >> MINB_W);

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        pos_next      = pos_reg;
        tvld_next     = tvld_reg;
        lv_next       = lv_reg;
        tgt_next      = tgt_reg;
        start_next    = start_reg;
        rm_lv_next    = rm_lv_reg;
        addr_next     = addr_reg;
        a_next        = a_reg;
        idx_next      = idx_reg;
        init_next     = init_reg;
        res_st_next   = res_st_reg;
        res_addr_next = res_addr_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_addr_next   = m_addr_reg;
        fl_we         = 1'b0;
        fl_waddr      = '0;
        fl_wdata      = '0;
        fl_re         = 1'b0;
        fl_raddr      = '0;
        tbl_we        = 1'b0;
        tbl_waddr     = '0;
        tbl_wdata     = '0;
        tbl_re        = 1'b0;
        tbl_raddr     = '0;

        case (state_reg)
            S_INIT: begin
                // seed the head of the top stacks
                fl_we    = 1'b1;
                fl_waddr = lvl_base(LVL_W'(init_reg));
                fl_wdata = lvl_size(LVL_W'(init_reg));
                if (init_reg == 2'(NINIT - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    init_next = init_reg + 2'd1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    if (s_operation == OP_FREE) begin
                        a_next = s_free_addr;
                        if (free_bad) begin
                            res_st_next   = ST_BAD_FREE;
                            res_addr_next = '0;
                            state_next    = S_DONE;
                        end else begin
                            tbl_re     = 1'b1;
                            tbl_raddr  = GRAN_W'(s_free_addr >> MINB_W);
                            state_next = S_F_TBL;
                        end
                    end else if (too_big || !src_found) begin
                        res_st_next   = ST_NO_SPACE;
                        res_addr_next = '0;
                        state_next    = S_DONE;
                    end else begin
                        cnt_next[src] = cnt_reg[src] - CNT_W'(1);
                        fl_re         = 1'b1;
                        fl_raddr      = lvl_base(src) + cnt_reg[src] - SLOT_W'(1);
                        lv_next       = src;
                        tgt_next      = target;
                        state_next    = S_A_POP;
                    end
                end
            end
            S_A_POP: begin
                addr_next = fl_rdata;
                if (lv_reg == tgt_reg) begin
                    state_next = S_A_TBL;
                end else begin
                    lv_next    = lv_reg + LVL_W'(1);
                    state_next = S_A_SPLT;
                end
            end
            S_A_SPLT: begin
                // upper half goes onto its level's stack if it has room
                if (cnt_reg[lv_reg] < lvl_cap(lv_reg)) begin
                    fl_we            = 1'b1;
                    fl_waddr         = lvl_base(lv_reg) + cnt_reg[lv_reg];
                    fl_wdata         = addr_reg + lvl_size(lv_reg);
                    cnt_next[lv_reg] = cnt_reg[lv_reg] + CNT_W'(1);
                end
                if (lv_reg == tgt_reg) begin
                    state_next = S_A_TBL;
                end else begin
                    lv_next = lv_reg + LVL_W'(1);
                end
            end
            S_A_TBL: begin
                tbl_we        = 1'b1;
                tbl_waddr     = GRAN_W'(addr_reg >> MINB_W);
                tbl_wdata     = tgt_reg;
                tvld_next[GRAN_W'(addr_reg >> MINB_W)] = 1'b1;
                res_st_next   = ST_OK;
                res_addr_next = addr_reg;
                state_next    = S_DONE;
            end
            S_F_TBL: begin
                if (!tvld_reg[a_gran]) begin
                    res_st_next   = ST_BAD_FREE;
                    res_addr_next = '0;
                    state_next    = S_DONE;
                end else begin
                    lv_next    = tbl_rdata;
                    start_next = tbl_rdata;
                    addr_next  = a_reg;
                    state_next = S_F_LVL;
                end
            end
            S_F_LVL: begin
                // look for the buddy on this level
                if (lv_reg == '0 || cnt_reg[lv_reg] == '0) begin
                    state_next = S_F_ROOM;
                end else begin
                    idx_next   = '0;
                    fl_re      = 1'b1;
                    fl_raddr   = lvl_base(lv_reg);
                    state_next = S_F_CMP;
                end
            end
            S_F_CMP: begin
                if (fl_rdata == (addr_reg ^ lvl_size(lv_reg))) begin
                    pos_next[lv_reg] = idx_reg;
                    addr_next        = addr_reg & ~lvl_size(lv_reg);
                    lv_next          = lv_reg - LVL_W'(1);
                    state_next       = S_F_LVL;
                end else if ((idx_reg + CNT_W'(1)) < cnt_reg[lv_reg]) begin
                    idx_next = idx_reg + CNT_W'(1);
                    fl_re    = 1'b1;
                    fl_raddr = lvl_base(lv_reg) + idx_reg + SLOT_W'(1);
                end else begin
                    state_next = S_F_ROOM;
                end
            end
            S_F_ROOM: begin
                if (cnt_reg[lv_reg] >= lvl_cap(lv_reg)) begin
                    res_st_next   = ST_BAD_FREE;
                    res_addr_next = '0;
                    state_next    = S_DONE;
                end else if (start_reg == lv_reg) begin
                    state_next = S_F_PUSH;
                end else begin
                    rm_lv_next = start_reg;
                    state_next = S_F_RMV;
                end
            end
            S_F_RMV: begin
                // pull the buddy out of its stack, keeping order
                if ((pos_reg[rm_lv_reg] + CNT_W'(1)) < cnt_reg[rm_lv_reg]) begin
                    fl_re      = 1'b1;
                    fl_raddr   = lvl_base(rm_lv_reg) + pos_reg[rm_lv_reg] + SLOT_W'(1);
                    idx_next   = pos_reg[rm_lv_reg];
                    state_next = S_F_SHW;
                end else begin
                    cnt_next[rm_lv_reg] = cnt_reg[rm_lv_reg] - CNT_W'(1);
                    if ((rm_lv_reg - LVL_W'(1)) == lv_reg) begin
                        state_next = S_F_PUSH;
                    end else begin
                        rm_lv_next = rm_lv_reg - LVL_W'(1);
                    end
                end
            end
            S_F_SHW: begin
                fl_we    = 1'b1;
                fl_waddr = lvl_base(rm_lv_reg) + idx_reg;
                fl_wdata = fl_rdata;
                if ((idx_reg + CNT_W'(2)) < cnt_reg[rm_lv_reg]) begin
                    fl_re    = 1'b1;
                    fl_raddr = lvl_base(rm_lv_reg) + idx_reg + SLOT_W'(2);
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    cnt_next[rm_lv_reg] = cnt_reg[rm_lv_reg] - CNT_W'(1);
                    if ((rm_lv_reg - LVL_W'(1)) == lv_reg) begin
                        state_next = S_F_PUSH;
                    end else begin
                        rm_lv_next = rm_lv_reg - LVL_W'(1);
                        state_next = S_F_RMV;
                    end
                end
            end
            S_F_PUSH: begin
                fl_we             = 1'b1;
                fl_waddr          = lvl_base(lv_reg) + cnt_reg[lv_reg];
                fl_wdata          = addr_reg;
                cnt_next[lv_reg]  = cnt_reg[lv_reg] + CNT_W'(1);
                tvld_next[a_gran] = 1'b0;
                res_st_next       = ST_OK;
                res_addr_next     = '0;
                state_next        = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_st_reg;
                    m_addr_next   = res_addr_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            init_reg    <= '0;
            tvld_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int l = 0; l < LEVELS; l++) begin
                cnt_reg[l] <= (l < NINIT) ? CNT_W'(1) : '0;
            end
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            tvld_reg    <= tvld_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        lv_reg       <= lv_next;
        tgt_reg      <= tgt_next;
        start_reg    <= start_next;
        rm_lv_reg    <= rm_lv_next;
        addr_reg     <= addr_next;
        a_reg        <= a_next;
        idx_reg      <= idx_next;
        res_st_reg   <= res_st_next;
        res_addr_reg <= res_addr_next;
        m_status_reg <= m_status_next;
        m_addr_reg   <= m_addr_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_block_addr = m_addr_reg;

`ifndef SYNTH
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while busy");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_NO_SPACE || m_status == ST_BAD_FREE))
        else $error("unknown status code");

    a_block_aligned: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> (m_block_addr & MIN_MASK) == '0)
        else $error("block address not granule aligned");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_F_PUSH |-> cnt_reg[lv_reg] < lvl_cap(lv_reg))
        else $error("free push onto a full stack");

    a_fail_no_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_OK |-> m_block_addr == '0)
        else $error("failed transaction carries an address");
`endif

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import ba_pkg::*;

    localparam int AW        = 10;
    localparam int NLEV      = 7;
    localparam int TOPSZ     = 512;
    localparam int GRAN      = 128;
    localparam int CYC_LIMIT = 2000000;
    localparam int N_RANDOM  = 950;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    logic          s_operation;
    logic [AW-1:0] s_request_size;
    logic [AW-1:0] s_free_addr;
    logic          m_valid;
    logic          m_ready;
    logic [1:0]    m_status;
    logic [AW-1:0] m_block_addr;

    buddy_allocator i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_request_size(s_request_size),
        .s_free_addr   (s_free_addr),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_block_addr  (m_block_addr)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    typedef struct packed {
        logic [1:0]    status;
        logic [AW-1:0] addr;
    } alloc_result_t;

    // allocator shadow state
    int            lvl_list[NLEV][$];
    int            granule_size[GRAN];
    int            live_blocks[$];
    alloc_result_t pending_results[$];

    int  mismatches;
    int  cycle_count;

    function automatic int lsize(int lv);
        return TOPSZ >> lv;
    endfunction

    function automatic int find_in(int lv, int a);
        for (int i = 0; i < lvl_list[lv].size(); i++)
            if (lvl_list[lv][i] == a) return i;
        return -1;
    endfunction

    function automatic void shadow_reset();
        for (int lv = 0; lv < NLEV; lv++) lvl_list[lv].delete();
        for (int g = 0; g < GRAN; g++) granule_size[g] = 0;
        live_blocks.delete();
        lvl_list[0].push_back(512);
        lvl_list[1].push_back(256);
        lvl_list[2].push_back(128);
    endfunction

    // apply one request to the shadow state and return its result
    function automatic alloc_result_t predict_request(logic op, int n, int a);
        alloc_result_t r;
        int target, src, addr, lv, sz, start;
        r.status = ST_OK;
        r.addr   = '0;
        if (op == OP_ALLOC) begin
            if (n + 1 > TOPSZ) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            target = 0;
            while (target + 1 < NLEV && n + 1 <= lsize(target + 1)) target++;
            src = -1;
            for (lv = target; lv >= 0; lv--)
                if (lvl_list[lv].size() > 0) begin
                    src = lv;
                    break;
                end
            if (src < 0) begin
                r.status = ST_NO_SPACE;
                return r;
            end
            addr = lvl_list[src].pop_back();
            for (lv = src + 1; lv <= target; lv++)
                if (lvl_list[lv].size() < (1 << lv))
                    lvl_list[lv].push_back(addr + lsize(lv));
            granule_size[(addr / 8) % GRAN] = lsize(target);
            live_blocks.push_back(addr);
            r.addr = AW'(addr);
            return r;
        end
        r.status = ST_BAD_FREE;
        if (a % 8 != 0) return r;
        sz = granule_size[a / 8];
        if (sz == 0) return r;
        start = -1;
        for (lv = 0; lv < NLEV; lv++)
            if (lsize(lv) == sz) begin
                start = lv;
                break;
            end
        if (start < 0) return r;
        addr = a;
        lv = start;
        while (lv > 0 && find_in(lv, addr ^ lsize(lv)) >= 0) begin
            addr &= ~lsize(lv);
            lv--;
        end
        if (lvl_list[lv].size() >= (1 << lv)) return r;
        addr = a;
        lv = start;
        while (lv > 0 && find_in(lv, addr ^ lsize(lv)) >= 0) begin
            lvl_list[lv].delete(find_in(lv, addr ^ lsize(lv)));
            addr &= ~lsize(lv);
            lv--;
        end
        lvl_list[lv].push_back(addr);
        granule_size[a / 8] = 0;
        foreach (live_blocks[i])
            if (live_blocks[i] == a) begin
                live_blocks.delete(i);
                break;
            end
        r.status = ST_OK;
        return r;
    endfunction

    // drive one request transaction, predicting at acceptance
    task automatic send_request(logic op, int n, int a, bit has_exp, alloc_result_t exp_r);
        alloc_result_t p;
        int gap;
        gap = $urandom_range(3) == 0 ? 0 : $urandom_range(19);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_operation    <= op;
        s_request_size <= AW'(n);
        s_free_addr    <= AW'(a);
        do @(posedge aclk); while (!s_ready);
        p = predict_request(op, n, a);
        if (has_exp && p != exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("table row disagrees with predictor: exp %0d/%0d pred %0d/%0d",
                         exp_r.status, exp_r.addr, p.status, p.addr);
        end
        pending_results.push_back(p);
    endtask

    // directed table
    typedef struct {
        logic          op;
        int            n;
        int            a;
        bit            has_exp;
        alloc_result_t exp_r;
    } table_row_t;

    table_row_t rows[$];

    function automatic void add_row(logic op, int n, int a, bit he, logic [1:0] st, int ad);
        table_row_t t;
        t.op = op; t.n = n; t.a = a; t.has_exp = he;
        t.exp_r.status = st; t.exp_r.addr = AW'(ad);
        rows.push_back(t);
    endfunction

    // result checker
    initial begin
        alloc_result_t e;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %0d/%0d", m_status, m_block_addr);
                end else begin
                    e = pending_results.pop_front();
                    if (m_status !== e.status || m_block_addr !== e.addr) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp status %0d addr %0d, got %0d addr %0d",
                                     e.status, e.addr, m_status, m_block_addr);
                    end
                end
            end
        end
    end

    // result stall
    initial begin
        int stall;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                stall--;
            end else begin
                m_ready <= 1'b1;
                if (m_valid) stall = ($urandom_range(3) == 0) ? 0 : $urandom_range(19);
            end
        end
    end

    // timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYC_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        int k, pick;
        alloc_result_t none;
        none = '0;
        mismatches = 0;
        cycle_count = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_operation = OP_ALLOC;
        s_request_size = '0;
        s_free_addr = '0;
        shadow_reset();
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // extremes, splits, errors, merges
        add_row(OP_FREE,  0,    512, 1, ST_BAD_FREE, 0);
        add_row(OP_ALLOC, 1023, 0,   1, ST_NO_SPACE, 0);
        add_row(OP_ALLOC, 512,  0,   1, ST_NO_SPACE, 0);
        add_row(OP_ALLOC, 511,  0,   1, ST_OK,       512);
        add_row(OP_ALLOC, 0,    0,   1, ST_OK,       128);
        add_row(OP_ALLOC, 7,    0,   0, ST_OK,       0);
        add_row(OP_ALLOC, 8,    0,   0, ST_OK,       0);
        add_row(OP_FREE,  0,    129, 1, ST_BAD_FREE, 0);
        add_row(OP_FREE,  0,    1023,1, ST_BAD_FREE, 0);
        add_row(OP_FREE,  0,    128, 0, ST_OK,       0);
        add_row(OP_FREE,  0,    128, 1, ST_BAD_FREE, 0);
        add_row(OP_ALLOC, 255,  0,   0, ST_OK,       0);
        add_row(OP_ALLOC, 300,  0,   1, ST_NO_SPACE, 0);
        add_row(OP_FREE,  0,    512, 0, ST_OK,       0);
        add_row(OP_ALLOC, 15,   0,   0, ST_OK,       0);
        add_row(OP_ALLOC, 63,   0,   0, ST_OK,       0);
        add_row(OP_FREE,  0,    0,   1, ST_BAD_FREE, 0);
        foreach (rows[i])
            send_request(rows[i].op, rows[i].n, rows[i].a, rows[i].has_exp, rows[i].exp_r);

        // random: mostly frees of live blocks and small allocations
        for (k = 0; k < N_RANDOM; k++) begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_request(OP_ALLOC, 0, $urandom_range(1023),
                             0, none);
            else if (pick < 45)
                send_request(OP_ALLOC, $urandom_range(1023), $urandom_range(1023), 0, none);
            else if (pick < 90 && live_blocks.size() > 0)
                send_request(OP_FREE, $urandom_range(1023),
                             live_blocks[$urandom_range(live_blocks.size() - 1)], 0, none);
            else
                send_request(OP_FREE, $urandom_range(1023), $urandom_range(1023), 0, none);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

FILE: files.f
sv/ba_pkg.sv
sv/ba_flist.sv
sv/buddy_allocator.sv
test/testbench.sv
